>>> rtl/csh_pkg.sv
// ----------------------------------------------------------------------------
// csh_pkg: shared types and constants of the C syntax highlight classifier
// Holds the queue item, highlight class codes, register indexes and the
// keyword tables.
// ----------------------------------------------------------------------------
package csh_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       first;
		logic       sep;
	} csh_item_t;

	typedef enum logic [2:0] {
		CLS_NORMAL,
		CLS_COMMENT,
		CLS_BLOCK,
		CLS_KEYWORD,
		CLS_TYPE,
		CLS_STRING,
		CLS_NUMBER
	} csh_class_t;

	localparam logic [1:0] CFG_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_NUMBERS = 2'd1;
	localparam logic [1:0] CFG_STRINGS = 2'd2;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int WORD_N = 23;
	localparam int KW_N   = 15;
	localparam int WORD_MAX = 8;

	localparam logic [63:0] WORD_TEXT [WORD_N] = '{
		{16'h0, "switch"}, {48'h0, "if"}, {24'h0, "while"}, {40'h0, "for"},
		{24'h0, "break"}, "continue", {16'h0, "return"}, {32'h0, "else"},
		{16'h0, "struct"}, {24'h0, "union"}, {8'h0, "typedef"},
		{16'h0, "static"}, {32'h0, "enum"}, {24'h0, "class"}, {32'h0, "case"},
		{40'h0, "int"}, {32'h0, "long"}, {16'h0, "double"}, {24'h0, "float"},
		{32'h0, "char"}, "unsigned", {16'h0, "signed"}, {32'h0, "void"}
	};

	localparam logic [3:0] WORD_LEN [WORD_N] = '{
		4'd6, 4'd2, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd6, 4'd5, 4'd7,
		4'd6, 4'd4, 4'd5, 4'd4,
		4'd3, 4'd4, 4'd6, 4'd5, 4'd4, 4'd8, 4'd6, 4'd4
	};

	function automatic logic is_sep(input logic [7:0] c);
		logic r;
		r = (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		r = r || c == ","  || c == "." || c == "(" || c == ")" || c == "+";
		r = r || c == "-"  || c == "/" || c == "*" || c == "=" || c == "~";
		r = r || c == "%"  || c == "<" || c == ">" || c == "[" || c == "]";
		r = r || c == ";";
		return r;
	endfunction

endpackage

>>> rtl/csh_front.sv
// ----------------------------------------------------------------------------
// csh_front: input stage and character queue
// Accepts characters, tags separators and holds them in a four-entry queue
// ahead of the classifier.
// ----------------------------------------------------------------------------
module csh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         character,
	input  logic               last_of_line,
	input  logic               first_line,
	output logic               out_valid,
	input  logic               out_ready,
	output csh_pkg::csh_item_t out_item
);
	import csh_pkg::*;

	csh_item_t  mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = cnt_q != 3'd4;
	assign out_valid = cnt_q != 3'd0;
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{ch: character, last: last_of_line, first: first_line,
				sep: is_sep(character)};
		end
	end

endmodule

>>> rtl/csh_back.sv
// ----------------------------------------------------------------------------
// csh_back: lookahead window and highlight classifier
// Holds the window, classifies its head character and registers the result.
// ----------------------------------------------------------------------------
module csh_back #(
	parameter int LOOKAHEAD = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_enable,
	input  logic [1:0]         write_index,
	input  logic               write_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  csh_pkg::csh_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_character,
	output logic [2:0]         highlight_class,
	output logic               line_end,
	output logic               comment_open_after
);
	import csh_pkg::*;

	localparam int CW = $clog2(LOOKAHEAD + 1);

	logic [7:0]  win_q [LOOKAHEAD];
	logic        sepw_q [LOOKAHEAD];
	logic [CW-1:0] count_q;
	logic        drain_q;
	logic        en_q, num_q, str_q;
	logic        bco_q, esc_q, psep_q, rolc_q;
	logic [7:0]  sq_q;
	csh_class_t  pcls_q, frcls_q;
	logic [2:0]  frc_q;
	logic        out_valid_q;
	logic [7:0]  och_q;
	csh_class_t  ocls_q;
	logic        oend_q, oopen_q;

	logic [7:0]  wv [LOOKAHEAD];
	logic        sv [LOOKAHEAD];
	logic [CW-1:0] nv;
	logic        advance, insert, line_done, emit, at_end;
	logic        bco_n, esc_n, psep_n, rolc_n;
	logic [7:0]  sq_n, c, nxt;
	csh_class_t  cls, frcls_n;
	logic [2:0]  frc_n;
	logic        kw_hit, ty_hit, hit, sep_at;
	logic [3:0]  wlen;
	logic        in_str, dig;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = advance && !drain_q;
	assign insert    = in_valid && in_ready;
	assign line_done = drain_q || (insert && in_item.last);
	assign nv        = count_q + CW'(insert);
	assign emit      = advance && (drain_q ||
		(insert && (in_item.last || nv == CW'(LOOKAHEAD))));
	assign at_end    = line_done && nv == CW'(1);

	always_comb begin
		for (int i = 0; i < LOOKAHEAD; i++) begin
			wv[i] = win_q[i];
			sv[i] = sepw_q[i];
			if (insert && count_q == CW'(i)) begin
				wv[i] = in_item.ch;
				sv[i] = in_item.sep;
			end
		end
	end

	always_comb begin
		kw_hit = 1'b0;
		ty_hit = 1'b0;
		wlen   = 4'd0;
		for (int w = 0; w < WORD_N; w++) begin
			hit = 1'b1;
			for (int k = 0; k < WORD_MAX; k++) begin
				if (k < int'(WORD_LEN[w]) &&
					wv[k] != WORD_TEXT[w][(int'(WORD_LEN[w]) - 1 - k) * 8 +: 8]) begin
					hit = 1'b0;
				end
			end
			sep_at = 1'b0;
			for (int p = 0; p <= WORD_MAX; p++) begin
				if (p == int'(WORD_LEN[w])) sep_at = sv[p];
			end
			if (hit && sep_at) begin
				if (w < KW_N) kw_hit = 1'b1;
				else ty_hit = 1'b1;
				wlen = WORD_LEN[w];
			end
		end
	end

	always_comb begin
		c       = wv[0];
		nxt     = wv[1];
		in_str  = sq_q != 8'd0;
		dig     = c >= CH_ZERO && c <= CH_NINE;
		bco_n   = (insert && count_q == '0 && in_item.first) ? 1'b0 : bco_q;
		esc_n   = esc_q;
		psep_n  = psep_q;
		rolc_n  = rolc_q;
		sq_n    = sq_q;
		frc_n   = frc_q;
		frcls_n = frcls_q;
		cls     = CLS_NORMAL;
		if (frc_q != 3'd0) begin
			frc_n = frc_q - 3'd1;
			cls   = frcls_q;
		end else if (rolc_q) begin
			cls = CLS_COMMENT;
		end else if (!en_q) begin
			cls = CLS_NORMAL;
		end else if (!in_str && !bco_n && c == CH_SLASH && nxt == CH_SLASH) begin
			rolc_n = 1'b1;
			cls    = CLS_COMMENT;
		end else if (!in_str && bco_n) begin
			cls = CLS_BLOCK;
			if (c == CH_STAR && nxt == CH_SLASH) begin
				frc_n   = 3'd1;
				frcls_n = CLS_BLOCK;
				bco_n   = 1'b0;
				psep_n  = 1'b1;
			end
		end else if (!in_str && c == CH_SLASH && nxt == CH_STAR) begin
			cls     = CLS_BLOCK;
			frc_n   = 3'd1;
			frcls_n = CLS_BLOCK;
			bco_n   = 1'b1;
		end else if (str_q && in_str) begin
			cls = CLS_STRING;
			if (esc_q) begin
				esc_n = 1'b0;
			end else if (c == CH_BSL && nv > CW'(1)) begin
				esc_n = 1'b1;
			end else begin
				if (c == sq_q) sq_n = 8'd0;
				psep_n = 1'b1;
			end
		end else if (str_q && (c == CH_DQ || c == CH_SQ)) begin
			sq_n = c;
			cls  = CLS_STRING;
		end else if (num_q && ((dig && (psep_q || pcls_q == CLS_NUMBER)) ||
			(c == CH_DOT && pcls_q == CLS_NUMBER))) begin
			cls    = CLS_NUMBER;
			psep_n = 1'b0;
		end else if (psep_q && (kw_hit || ty_hit)) begin
			cls     = kw_hit ? CLS_KEYWORD : CLS_TYPE;
			frc_n   = wlen[2:0] - 3'd1;
			frcls_n = cls;
			psep_n  = 1'b0;
		end else begin
			psep_n = sepw_q[0] && !(insert && count_q == '0) || (insert && count_q == '0 &&
				in_item.sep);
			cls = CLS_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOOKAHEAD; i++) begin
				win_q[i]  <= 8'd0;
				sepw_q[i] <= 1'b1;
			end
			count_q     <= '0;
			drain_q     <= 1'b0;
			en_q        <= 1'b1;
			num_q       <= 1'b1;
			str_q       <= 1'b1;
			bco_q       <= 1'b0;
			esc_q       <= 1'b0;
			psep_q      <= 1'b1;
			rolc_q      <= 1'b0;
			sq_q        <= 8'd0;
			pcls_q      <= CLS_NORMAL;
			frc_q       <= 3'd0;
			frcls_q     <= CLS_NORMAL;
			out_valid_q <= 1'b0;
		end else begin
			if (write_enable) begin
				case (write_index)
					CFG_ENABLE:  en_q  <= write_data;
					CFG_NUMBERS: num_q <= write_data;
					CFG_STRINGS: str_q <= write_data;
					default: ;
				endcase
			end
			if (advance) out_valid_q <= emit;
			if (emit) begin
				for (int i = 0; i < LOOKAHEAD - 1; i++) begin
					win_q[i]  <= wv[i + 1];
					sepw_q[i] <= sv[i + 1];
				end
				win_q[LOOKAHEAD - 1]  <= 8'd0;
				sepw_q[LOOKAHEAD - 1] <= 1'b1;
				count_q <= nv - CW'(1);
				drain_q <= line_done && nv > CW'(1);
				bco_q   <= bco_n;
				if (at_end) begin
					esc_q   <= 1'b0;
					psep_q  <= 1'b1;
					rolc_q  <= 1'b0;
					sq_q    <= 8'd0;
					pcls_q  <= CLS_NORMAL;
					frc_q   <= 3'd0;
					frcls_q <= CLS_NORMAL;
				end else begin
					esc_q   <= esc_n;
					psep_q  <= psep_n;
					rolc_q  <= rolc_n;
					sq_q    <= sq_n;
					frc_q   <= frc_n;
					frcls_q <= frcls_n;
					if (en_q || frc_q != 3'd0 || rolc_q) pcls_q <= cls;
				end
			end else if (insert) begin
				for (int i = 0; i < LOOKAHEAD; i++) begin
					win_q[i]  <= wv[i];
					sepw_q[i] <= sv[i];
				end
				count_q <= nv;
				if (count_q == '0 && in_item.first) bco_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			och_q   <= c;
			ocls_q  <= cls;
			oend_q  <= at_end;
			oopen_q <= at_end && bco_n;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_character      = och_q;
	assign highlight_class    = ocls_q;
	assign line_end           = oend_q;
	assign comment_open_after = oopen_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LOOKAHEAD))
		else $error("window count beyond depth");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> count_q != '0)
		else $error("draining an empty window");
	a_no_take_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !in_ready)
		else $error("transfer taken during drain");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frc_q != 3'd0 |-> (frcls_q == CLS_BLOCK || frcls_q == CLS_KEYWORD ||
		frcls_q == CLS_TYPE))
		else $error("forced run with wrong class");
`endif

endmodule

>>> rtl/c_syntax_highlight_classifier.sv
// ----------------------------------------------------------------------------
// c_syntax_highlight_classifier: C source highlighting lexer
// Gives each rendered character of a text line a highlight class.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the queue has room. Results trail
// the input by LOOKAHEAD-1 characters of the same line, held in the lookahead
// window; the last character of a line drains the window, one result per
// cycle while the output is not stalled, so a line end stalls the classifier
// input until the window has drained. A four-entry queue in front of the
// classifier absorbs input while the window drains or the output stalls.
module c_syntax_highlight_classifier #(
	parameter int LOOKAHEAD = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       write_enable,
	input  logic [1:0] write_index,
	input  logic       write_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       last_of_line,
	input  logic       first_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_character,
	output logic [2:0] highlight_class,
	output logic       line_end,
	output logic       comment_open_after
);
	import csh_pkg::*;

	csh_item_t q_item;
	logic      q_valid;
	logic      q_ready;

	csh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.character    (character),
		.last_of_line (last_of_line),
		.first_line   (first_line),
		.out_valid    (q_valid),
		.out_ready    (q_ready),
		.out_item     (q_item)
	);

	csh_back #(.LOOKAHEAD(LOOKAHEAD)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.write_enable       (write_enable),
		.write_index        (write_index),
		.write_data         (write_data),
		.in_valid           (q_valid),
		.in_ready           (q_ready),
		.in_item            (q_item),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_character      (out_character),
		.highlight_class    (highlight_class),
		.line_end           (line_end),
		.comment_open_after (comment_open_after)
	);

endmodule
